// File: design/ecvm_pkg.sv
package ecvm_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CORDIC_STEPS   = 30;
  localparam int WORDS          = 52;
  localparam int IDX_W          = 6;
  localparam int ZW             = 34;
  localparam int XW             = 34;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

  // arctangent of 2^-i in 2^32-per-turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2F9;
        5'd15: r = 32'h0000517C; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517; 5'd20: r = 32'h0000028B;
        5'd21: r = 32'h00000145; 5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
        5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
        5'd27: r = 32'h00000005; 5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

endpackage

// File: design/ecvm_cordic_cell.sv
module ecvm_cordic_cell
  import ecvm_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cvec_t [2:0] din,
  output cvec_t [2:0] dout
);

  cvec_t [2:0] nxt;
  logic signed [ZW-1:0] at;

  // one micro-rotation for each of the three angles
  always_comb begin
    at = ZW'(atan_turn(5'(STEP)));
    for (int k = 0; k < 3; k++) begin
      if (!din[k].z[ZW-1]) begin
        nxt[k].x = din[k].x - (din[k].y >>> STEP);
        nxt[k].y = din[k].y + (din[k].x >>> STEP);
        nxt[k].z = din[k].z - at;
      end else begin
        nxt[k].x = din[k].x + (din[k].y >>> STEP);
        nxt[k].y = din[k].y - (din[k].x >>> STEP);
        nxt[k].z = din[k].z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end

endmodule

// File: design/ecvm_matrix.sv
module ecvm_matrix
  import ecvm_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  cvec_t [2:0] cv,
  input  logic [2:0] flip,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic signed [31:0] m [0:10],
  output logic signed [31:0] t [0:2],
  output logic signed [31:0] qx,
  output logic signed [31:0] qy,
  output logic signed [31:0] qz
);
  localparam int SH = 30 - FRAC_BITS;
  localparam int FW = FRAC_BITS + 3;
  localparam logic signed [XW-1:0] ONE30 = XW'(64'sd1 << 30);
  // 32 by 33 bit products, three of them summed
  localparam int TW = 65;

  function automatic logic signed [FW-1:0] fin(input logic signed [XW-1:0] v,
                                               input logic f);
    logic signed [XW:0] a;
    logic signed [XW:0] r;
    begin
      a = f ? -(XW+1)'(v) : (XW+1)'(v);
      if (a > (XW+1)'(ONE30)) a = (XW+1)'(ONE30);
      if (a < -(XW+1)'(ONE30)) a = -(XW+1)'(ONE30);
      r = (a + ((XW+1)'(1) <<< (SH - 1))) >>> SH;
      return FW'(r);
    end
  endfunction

  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    begin
      p = 64'(a) * 64'(b);
      p = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return p[31:0];
    end
  endfunction

  logic signed [31:0] sx, cx, sy, cy, sz, cz;
  logic signed [31:0] cc, cs, sc, ss;
  logic signed [31:0] sx2, cx2, sy2, cy2, sz2, cz2;
  logic signed [31:0] r [0:10];
  logic signed [31:0] p1x, p1y, p1z, p2x, p2y, p2z, p3x, p3y, p3z;
  logic signed [32:0] nx, ny, nz;
  logic signed [TW-1:0] d0 [0:2];
  logic signed [TW-1:0] d1 [0:2];
  logic signed [TW-1:0] d2 [0:2];

  // stage a: final sine and cosine
  always_ff @(posedge clk) begin
    if (en) begin
      cx <= 32'(fin(cv[0].x, flip[0])); sx <= 32'(fin(cv[0].y, flip[0]));
      cy <= 32'(fin(cv[1].x, flip[1])); sy <= 32'(fin(cv[1].y, flip[1]));
      cz <= 32'(fin(cv[2].x, flip[2])); sz <= 32'(fin(cv[2].y, flip[2]));
      p1x <= px; p1y <= py; p1z <= pz;
    end
  end

  // stage b: pair products
  always_ff @(posedge clk) begin
    if (en) begin
      cc <= fmul(cy, cz); cs <= fmul(cy, sz); sc <= fmul(sy, cz); ss <= fmul(sy, sz);
      sx2 <= sx; cx2 <= cx; sy2 <= sy; cy2 <= cy; sz2 <= sz; cz2 <= cz;
      p2x <= p1x; p2y <= p1y; p2z <= p1z;
    end
  end

  // stage c: rotation terms
  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= cc + fmul(ss, sx2);
      r[1] <= fmul(cx2, sz2);
      r[2] <= fmul(cs, sx2) - sc;
      r[3] <= '0;
      r[4] <= fmul(sc, sx2) - cs;
      r[5] <= fmul(cx2, cz2);
      r[6] <= fmul(cc, sx2) + ss;
      r[7] <= '0;
      r[8] <= fmul(cx2, sy2);
      r[9] <= -sx2;
      r[10] <= fmul(cy2, cx2);
      p3x <= p2x; p3y <= p2y; p3z <= p2z;
    end
  end

  // negated position, exact for the most negative value
  always_comb begin
    nx = -(33'(p3x));
    ny = -(33'(p3y));
    nz = -(33'(p3z));
  end

  // stage d: translation products, one register per product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d0[k] <= r[4*k] * nx;
        d1[k] <= r[4*k+1] * ny;
        d2[k] <= r[4*k+2] * nz;
      end
      m <= r;
      qx <= p3x; qy <= p3y; qz <= p3z;
    end
  end

  // stage e is a combinational sum, rounded and saturated onto the output
  logic signed [TW-1:0] sm [0:2];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sm[k] = d0[k] + d1[k] + d2[k] + (TW'(1) <<< (FRAC_BITS - 1));
      sm[k] = sm[k] >>> FRAC_BITS;
      if (sm[k] > TW'(32'sh7fffffff)) t[k] = 32'sh7fffffff;
      else if (sm[k] < -TW'(64'sh80000000)) t[k] = 32'sh80000000;
      else t[k] = sm[k][31:0];
    end
  end

endmodule

// File: design/euler_camera_view_matrix.sv
// Camera view-matrix packet generator.
// s_axis: one item per camera update; tdata packs, from bit 0 up: pitch_angle,
// yaw_angle, roll_angle (16 bits each), pos_x, pos_y, pos_z (32 bits each).
// m_axis: 52 words per item; tdata packs word_index (6) then word_value (32),
// padded to 40 bits; tlast marks word 51.
// Sine and cosine come from a row of 30 CORDIC cells that pass the three angles
// on together, followed by a four-stage matrix pipeline. The rotation terms,
// translation and position are held in output registers and the packet is sent
// from them one word per cycle while the receiver is ready; the next item is
// taken into the pipeline while the previous packet drains. When the receiver
// stalls, the pipeline stalls only once a finished item waits at its end, and
// nothing is lost.
// Reset clears every valid flag and the word counter.
module euler_camera_view_matrix
  import ecvm_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,   // pitch, yaw, roll, pos_x, pos_y, pos_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,   // word_index, word_value
  output logic         m_axis_tlast
);
  localparam int DEPTH = CORDIC_STEPS + 4;

  cvec_t [2:0] cd [0:CORDIC_STEPS];
  logic [2:0] fl [0:CORDIC_STEPS];
  logic signed [31:0] ppx [0:CORDIC_STEPS];
  logic signed [31:0] ppy [0:CORDIC_STEPS];
  logic signed [31:0] ppz [0:CORDIC_STEPS];
  logic [DEPTH-1:0] vld;
  logic en, busy, load;
  logic [IDX_W-1:0] idx;
  logic signed [31:0] m [0:10];
  logic signed [31:0] t [0:2];
  logic signed [31:0] qx, qy, qz;
  logic signed [31:0] hm [0:10];
  logic signed [31:0] ht [0:2];
  logic signed [31:0] hqx, hqy, hqz;
  logic signed [31:0] wv;

  // pipeline advances unless a finished packet waits on a busy unloader
  assign load = vld[DEPTH-1] && (!busy || (m_axis_tready && idx == LAST_IDX));
  assign en = !vld[DEPTH-1] || load;
  assign s_axis_tready = en;

  // angle preparation into the first cell
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [31:0] a;
      a = 32'(s_axis_tdata[16*k +: 16] & 16'((17'd1 << ANGLE_BITS) - 1)) << (32 - ANGLE_BITS);
      fl[0][k] = a[31] ^ a[30];
      if (fl[0][k]) a = a ^ 32'h80000000;
      cd[0][k].x = XW'(652032874);
      cd[0][k].y = '0;
      cd[0][k].z = ZW'(signed'(a));
    end
    ppx[0] = s_axis_tdata[79:48];
    ppy[0] = s_axis_tdata[111:80];
    ppz[0] = s_axis_tdata[143:112];
  end

  // row of CORDIC cells
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ecvm_cordic_cell #(.STEP(g)) u_cell (
      .clk(clk), .en(en), .din(cd[g]), .dout(cd[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        fl[g+1] <= fl[g]; ppx[g+1] <= ppx[g]; ppy[g+1] <= ppy[g]; ppz[g+1] <= ppz[g];
      end
    end
  end

  ecvm_matrix #(.FRAC_BITS(FRAC_BITS)) u_mat (
    .clk(clk), .en(en), .cv(cd[CORDIC_STEPS]), .flip(fl[CORDIC_STEPS]),
    .px(ppx[CORDIC_STEPS]), .py(ppy[CORDIC_STEPS]), .pz(ppz[CORDIC_STEPS]),
    .m(m), .t(t), .qx(qx), .qy(qy), .qz(qz)
  );

  // valid flags along the pipeline
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], s_axis_tvalid};
  end

  // packet unloader
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (busy && m_axis_tready) begin
      if (idx == LAST_IDX) busy <= 1'b0;
      idx <= idx + 1'b1;
    end
  end

  // packet contents held while the words go out
  always_ff @(posedge clk) begin
    if (load) begin
      hm <= m;
      ht <= t;
      hqx <= qx; hqy <= qy; hqz <= qz;
    end
  end

  // word select by position in the packet
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  always_comb begin
    case (idx) inside
      6'd0, 6'd16, 6'd40:           wv = hm[0];
      6'd1, 6'd20, 6'd41:           wv = hm[1];
      6'd2, 6'd24, 6'd42:           wv = hm[2];
      6'd4, 6'd17, 6'd32:           wv = hm[4];
      6'd5, 6'd21, 6'd33:           wv = hm[5];
      6'd6, 6'd25, 6'd34:           wv = hm[6];
      6'd8, 6'd18, 6'd36:           wv = hm[8];
      6'd9, 6'd22, 6'd37:           wv = hm[9];
      6'd10, 6'd26, 6'd38:          wv = hm[10];
      6'd12, 6'd48:                 wv = hqx;
      6'd13, 6'd49:                 wv = hqy;
      6'd14, 6'd50:                 wv = hqz;
      6'd28:                        wv = ht[0];
      6'd29:                        wv = ht[1];
      6'd30:                        wv = ht[2];
      6'd15, 6'd31, 6'd35, 6'd39,
      6'd43, 6'd51:                 wv = ONE;
      default:                      wv = '0;
    endcase
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tlast  = (idx == LAST_IDX);
  assign m_axis_tdata  = {2'b00, wv, idx};

endmodule
